// ===== src/u16dec_pkg.sv =====
package u16dec_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] CFG_UTF16_MODE        = 3'd0;
    localparam logic [2:0] CFG_DEFAULT_IN_LITTLE = 3'd1;
    localparam logic [2:0] CFG_DETECT_BOM        = 3'd2;
    localparam logic [2:0] CFG_OUT_LITTLE        = 3'd3;
    localparam logic [2:0] CFG_EMIT_OUT_BOM      = 3'd4;
    localparam logic [2:0] CFG_ILLEGAL_ACTION    = 3'd5;

    // Request types
    localparam logic REQ_DATA    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_BOM     = 2'd1;
    localparam logic [1:0] KIND_REPLACE = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Illegal character actions (the unused code behaves as ACT_ERROR)
    localparam logic [1:0] ACT_ERROR   = 2'd0;
    localparam logic [1:0] ACT_DISCARD = 2'd1;
    localparam logic [1:0] ACT_REPLACE = 2'd2;

    // Code unit and code point constants
    localparam int unsigned CP_W      = 21;
    localparam int unsigned PAIR_BITS = 10;

    localparam logic [15:0] SUR_FIRST      = 16'hD800;
    localparam logic [15:0] HIGH_SUR_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_SUR_FIRST  = 16'hDC00;
    localparam logic [15:0] SUR_LAST       = 16'hDFFF;
    localparam logic [15:0] NONCHAR_FIRST  = 16'hFFFE;
    localparam logic [15:0] BOM_UNIT       = 16'hFEFF;
    localparam logic [15:0] BOM_SWAPPED    = 16'hFFFE;
    localparam logic [CP_W-1:0] PLANE1_BASE = 21'h010000;
    localparam logic [CP_W-1:0] REPLACE_CP  = 21'h00FFFD;

    // Output queue geometry
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    typedef struct packed {
        logic       utf16_mode;
        logic       default_in_little;
        logic       detect_bom;
        logic       out_little;
        logic       emit_out_bom;
        logic [1:0] illegal_action;
    } cfg_t;

    typedef struct packed {
        logic [31:0] out_word;
        logic [1:0]  kind;
        logic        last;
    } result_t;

    // Up to two results from one input word
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } dec_out_t;

    function automatic logic [31:0] place_word(input logic [31:0] w, input logic little);
        logic [31:0] swapped;
        swapped = {w[7:0], w[15:8], w[23:16], w[31:24]};
        return little ? swapped : w;
    endfunction

endpackage

// ===== src/u16dec_in_if.sv =====
interface u16dec_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

// ===== src/u16dec_out_if.sv =====
interface u16dec_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word;
    logic [1:0]  kind;
    logic        last;

    modport source (output valid, output out_word, output kind, output last, input ready);
    modport sink   (input valid, input out_word, input kind, input last, output ready);
endinterface

// ===== src/u16dec_decode.sv =====
module u16dec_decode
    import u16dec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       fire,
    input  logic       req_type,
    input  logic [7:0] data_byte,
    output dec_out_t   results
);

    logic [7:0]  held_byte_reg,    held_byte_next;
    logic        have_byte_reg,    have_byte_next;
    logic [15:0] pending_high_reg, pending_high_next;
    logic        have_high_reg,    have_high_next;
    logic        bom_checked_reg,  bom_checked_next;
    logic        in_little_reg,    in_little_next;
    logic        out_bom_done_reg, out_bom_done_next;

    logic [15:0]     big;
    logic [15:0]     unit;
    logic            is_sur;
    logic            is_low;
    logic            do_emit;
    logic            do_ill;
    logic [CP_W-1:0] emit_cp;
    logic [1:0]      emit_kind;

    assign big    = {held_byte_reg, data_byte};
    assign unit   = in_little_reg ? {data_byte, held_byte_reg} : big;
    assign is_sur = (unit >= SUR_FIRST) && (unit <= SUR_LAST);
    assign is_low = (unit >= LOW_SUR_FIRST) && (unit <= SUR_LAST);

    always_comb
    begin
        held_byte_next    = held_byte_reg;
        have_byte_next    = have_byte_reg;
        pending_high_next = pending_high_reg;
        have_high_next    = have_high_reg;
        bom_checked_next  = bom_checked_reg;
        in_little_next    = in_little_reg;
        out_bom_done_next = out_bom_done_reg;
        results           = '0;
        do_emit           = 1'b0;
        do_ill            = 1'b0;
        emit_cp           = '0;
        emit_kind         = KIND_CHAR;

        if (fire)
        begin
            if (req_type == REQ_RESTART)
            begin
                held_byte_next    = '0;
                have_byte_next    = 1'b0;
                pending_high_next = '0;
                have_high_next    = 1'b0;
                bom_checked_next  = ~cfg.detect_bom;
                in_little_next    = cfg.default_in_little;
                out_bom_done_next = ~cfg.emit_out_bom;
            end
            else if (!have_byte_reg)
            begin
                held_byte_next = data_byte;
                have_byte_next = 1'b1;
            end
            else
            begin
                have_byte_next   = 1'b0;
                bom_checked_next = 1'b1;
                if (!bom_checked_reg && big == BOM_UNIT)
                begin
                    in_little_next = 1'b0;
                end
                else if (!bom_checked_reg && big == BOM_SWAPPED)
                begin
                    in_little_next = 1'b1;
                end
                else if (have_high_reg)
                begin
                    have_high_next = 1'b0;
                    if (is_low)
                    begin
                        do_emit = 1'b1;
                        emit_cp = {1'b0, pending_high_reg[PAIR_BITS-1:0],
                                   unit[PAIR_BITS-1:0]} + PLANE1_BASE;
                    end
                    else
                    begin
                        do_ill = 1'b1;
                    end
                end
                else if (unit >= NONCHAR_FIRST)
                begin
                    do_ill = 1'b1;
                end
                else if (is_sur)
                begin
                    if (cfg.utf16_mode && unit <= HIGH_SUR_LAST)
                    begin
                        pending_high_next = unit;
                        have_high_next    = 1'b1;
                    end
                    else
                    begin
                        do_ill = 1'b1;
                    end
                end
                else
                begin
                    do_emit = 1'b1;
                    emit_cp = {5'b0, unit};
                end
            end
        end

        // Resolve an illegal character by the configured action
        if (do_ill)
        begin
            case (cfg.illegal_action)
                ACT_DISCARD:
                begin
                end
                ACT_REPLACE:
                begin
                    do_emit   = 1'b1;
                    emit_cp   = REPLACE_CP;
                    emit_kind = KIND_REPLACE;
                end
                default:
                begin
                    results.count = 2'd1;
                    results.first = '{out_word: '0, kind: KIND_ERROR, last: 1'b1};
                end
            endcase
        end

        // Precede the first character with the output mark if still due
        if (do_emit)
        begin
            if (!out_bom_done_reg)
            begin
                out_bom_done_next = 1'b1;
                results.count     = 2'd2;
                results.first     = '{out_word: place_word({16'b0, BOM_UNIT}, cfg.out_little),
                                      kind: KIND_BOM, last: 1'b0};
                results.second    = '{out_word: place_word({11'b0, emit_cp}, cfg.out_little),
                                      kind: emit_kind, last: 1'b1};
            end
            else
            begin
                results.count = 2'd1;
                results.first = '{out_word: place_word({11'b0, emit_cp}, cfg.out_little),
                                  kind: emit_kind, last: 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg    <= '0;
            have_byte_reg    <= 1'b0;
            pending_high_reg <= '0;
            have_high_reg    <= 1'b0;
            bom_checked_reg  <= 1'b0;
            in_little_reg    <= 1'b0;
            out_bom_done_reg <= 1'b0;
        end
        else
        begin
            held_byte_reg    <= held_byte_next;
            have_byte_reg    <= have_byte_next;
            pending_high_reg <= pending_high_next;
            have_high_reg    <= have_high_next;
            bom_checked_reg  <= bom_checked_next;
            in_little_reg    <= in_little_next;
            out_bom_done_reg <= out_bom_done_next;
        end
    end

endmodule

// ===== src/u16dec_outq.sv =====
module u16dec_outq
    import u16dec_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dec_out_t push,
    output logic     space_ok,
    output logic     head_valid,
    input  logic     head_taken,
    output result_t  head
);

    result_t             mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;
    logic                pop;

    assign head_valid = (count_reg != '0);
    assign pop        = head_valid && head_taken;
    assign space_ok   = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + QPTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/utf16_to_utf32_stream_decoder.sv =====
// A byte that completes a character has its result registered in the output queue on acceptance.
// Throughput: one input byte per cycle while the queue has room; results leave at one per
// cycle from a four-entry output queue while the sink is ready.
// Input is held off only while the output queue has fewer than two free entries.
// Reset (rst_n, asynchronous, active low) loads register defaults, clears decode state
// and empties the queue; a restart request clears decode state from current registers.
module utf16_to_utf32_stream_decoder
    import u16dec_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [1:0]          cfg_data,
    u16dec_in_if.sink           data,
    u16dec_out_if.source        result
);

    // Configuration registers. Writes touch no decode state: detect_bom,
    // default_in_little and emit_out_bom only matter at the next restart.
    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Handshake and the link between decoder and output queue
    logic     fire;
    logic     space_ok;
    dec_out_t dec_results;
    result_t  head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UTF16_MODE:        cfg_next.utf16_mode        = cfg_data[0];
                CFG_DEFAULT_IN_LITTLE: cfg_next.default_in_little = cfg_data[0];
                CFG_DETECT_BOM:        cfg_next.detect_bom        = cfg_data[0];
                CFG_OUT_LITTLE:        cfg_next.out_little        = cfg_data[0];
                CFG_EMIT_OUT_BOM:      cfg_next.emit_out_bom      = cfg_data[0];
                CFG_ILLEGAL_ACTION:    cfg_next.illegal_action    = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{utf16_mode: 1'b1, default_in_little: 1'b0, detect_bom: 1'b1,
                         out_little: 1'b0, emit_out_bom: 1'b1, illegal_action: ACT_ERROR};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept a word whenever the queue can take the two results it may cause;
    // this does not wait for the queue to drain.
    assign data.ready = space_ok;
    assign fire       = data.valid && space_ok;

    // Assemble units, track the byte order mark and surrogate pairs, and
    // produce up to two results for the accepted word in the same cycle.
    u16dec_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .fire      (fire),
        .req_type  (data.req_type),
        .data_byte (data.data_byte),
        .results   (dec_results)
    );

    // Hold results here until the sink takes them; it parts the two sides
    // so a stalled sink does not stall decoding until the queue fills.
    u16dec_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (dec_results),
        .space_ok   (space_ok),
        .head_valid (result.valid),
        .head_taken (result.ready),
        .head       (head)
    );

    assign result.out_word = head.out_word;
    assign result.kind     = head.kind;
    assign result.last     = head.last;

endmodule

// ===== src/u16dec_checker.sv =====
module u16dec_checker
    import u16dec_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_word,
    input logic [1:0]  kind,
    input logic        last
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(kind)
                                    && $stable(last))
        else $error("result changed while stalled");

    // The output mark is never the last result of its word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_BOM |-> !last)
        else $error("byte order mark marked last");

    // An error result carries a zero word and closes its word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |-> out_word == 32'd0 && last)
        else $error("malformed error result");

    // Results never appear without an accepted word just before
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without accepted word");

endmodule

bind utf16_to_utf32_stream_decoder u16dec_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (data.valid),
    .in_ready  (data.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_word  (result.out_word),
    .kind      (result.kind),
    .last      (result.last)
);
